FILE: rtl/gdad_pkg.sv
// Shared types, constants and month-length lookup for the date-advance unit.
package gdad_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 15;
    localparam int QUOT_W  = 8;   // year / 100, at most 163
    localparam int REM_W   = 7;   // year % 100

    localparam logic [YEAR_W-1:0]  YEAR_LIMIT = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST   = 5'd31;

    // floor(y / 100) = (y * 5243) >> 19, exact for any 14-bit y
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [6:0]  HUNDRED      = 7'd100;
    localparam logic [REM_W-1:0] REM_LAST = 7'd99;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic load;   // capture input beat
        logic div;    // year / 100
        logic rem;    // year % 100, century phase
        logic chk;    // validate start date
        logic step;   // advance by one month or finish the count
        logic fin;    // apply year saturation
    } gdad_cmd_t;

    typedef struct packed {
        logic date_ok;
        logic walk_done;
    } gdad_sts_t;

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                        input logic leap);
        logic [DAY_W-1:0] len;
        if (m == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (m >= MONTH_JAN && m <= MONTH_DEC) begin
            len = MONTH_LEN[m - MONTH_JAN];
        end else begin
            len = DAY_LAST;
        end
        return len;
    endfunction

endpackage

FILE: rtl/gdad_ctrl.sv
// Sequencing state machine for the date-advance unit.
module gdad_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic               out_fire,
    input  gdad_pkg::gdad_sts_t sts,
    output gdad_pkg::gdad_cmd_t cmd,
    output logic               in_ready,
    output logic               out_valid
);
    import gdad_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_REM  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_WALK = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = ST_REM;
            end
            ST_REM: begin
                cmd.rem    = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cmd.chk    = 1'b1;
                state_next = sts.date_ok ? ST_WALK : ST_OUT;
            end
            ST_WALK: begin
                if (sts.walk_done) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_OUT: begin
                if (out_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

endmodule

FILE: rtl/gdad_dp.sv
// Date registers, leap tracking and month-walk arithmetic.
module gdad_dp (
    input  logic                              aclk,
    input  gdad_pkg::gdad_cmd_t               cmd,
    input  logic [gdad_pkg::YEAR_W-1:0]       in_year,
    input  logic [gdad_pkg::MONTH_W-1:0]      in_month,
    input  logic [gdad_pkg::DAY_W-1:0]        in_day,
    input  logic [gdad_pkg::COUNT_W-1:0]      in_count,
    output gdad_pkg::gdad_sts_t               sts,
    output logic [gdad_pkg::YEAR_W-1:0]       res_year,
    output logic [gdad_pkg::MONTH_W-1:0]      res_month,
    output logic [gdad_pkg::DAY_W-1:0]        res_day,
    output logic                              res_bad,
    output logic                              res_ovf
);
    import gdad_pkg::*;

    logic [YEAR_W-1:0]  y_reg;
    logic [MONTH_W-1:0] m_reg;
    logic [DAY_W-1:0]   d_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [QUOT_W-1:0]  q_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [1:0]         cen_reg;
    logic               bad_reg, ovf_reg;

    logic [YEAR_W+12:0] prod;
    logic [YEAR_W-1:0]  q_times_100;
    logic [YEAR_W-1:0]  rem_full;
    logic               leap;
    logic [DAY_W-1:0]   mlen;
    logic [DAY_W-1:0]   left;
    logic [COUNT_W:0]   left_p1;
    logic               past_limit;

    assign prod        = y_reg * DIV100_MUL;
    assign q_times_100 = YEAR_W'(q_reg) * YEAR_W'(HUNDRED);
    assign rem_full    = y_reg - q_times_100;

    // y%4 == rem%4 since 100 is a multiple of 4
    assign leap = ((rem_reg[1:0] == 2'd0) && (rem_reg != '0))
                || ((rem_reg == '0) && (cen_reg == 2'd0));

    assign mlen       = days_in_month(m_reg, leap);
    assign left       = mlen - d_reg;
    assign left_p1    = {{(COUNT_W-DAY_W+1){1'b0}}, left} + 1'b1;
    assign past_limit = (y_reg > YEAR_LIMIT);

    assign sts.date_ok   = (m_reg inside {[MONTH_JAN:MONTH_DEC]})
                         && (d_reg != '0) && (d_reg <= mlen);
    assign sts.walk_done = (n_reg == '0) || past_limit;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            y_reg   <= in_year;
            m_reg   <= in_month;
            d_reg   <= in_day;
            n_reg   <= in_count;
            bad_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end
        if (cmd.div) begin
            q_reg <= prod[DIV100_SHIFT +: QUOT_W];
        end
        if (cmd.rem) begin
            rem_reg <= rem_full[REM_W-1:0];
            cen_reg <= q_reg[1:0];
        end
        if (cmd.chk && !sts.date_ok) begin
            bad_reg <= 1'b1;
        end
        if (cmd.step) begin
            if ({1'b0, n_reg} >= left_p1) begin
                n_reg <= n_reg - left_p1[COUNT_W-1:0];
                d_reg <= DAY_FIRST;
                if (m_reg == MONTH_DEC) begin
                    m_reg <= MONTH_JAN;
                    y_reg <= y_reg + 1'b1;
                    if (rem_reg == REM_LAST) begin
                        rem_reg <= '0;
                        cen_reg <= cen_reg + 1'b1;
                    end else begin
                        rem_reg <= rem_reg + 1'b1;
                    end
                end else begin
                    m_reg <= m_reg + 1'b1;
                end
            end else begin
                d_reg <= d_reg + n_reg[DAY_W-1:0];
                n_reg <= '0;
            end
        end
        if (cmd.fin && past_limit) begin
            y_reg   <= YEAR_LIMIT;
            m_reg   <= MONTH_DEC;
            d_reg   <= DAY_LAST;
            ovf_reg <= 1'b1;
        end
    end

    assign res_year  = y_reg;
    assign res_month = m_reg;
    assign res_day   = d_reg;
    assign res_bad   = bad_reg;
    assign res_ovf   = ovf_reg;

endmodule

FILE: rtl/gregorian_date_add_days_unit.sv
// Top level of the Gregorian date-advance unit.
//
//  channel | dir | tdata (low bit first)                      | tuser
//  s_      | in  | start_year, start_month, start_day, days    | -
//  m_      | out | result_year, result_month, result_day       | bad_date, year_overflow
//
// One beat at a time: setup steps (capture, year/100, year%100, date check), then
// one step per month crossed, one to add what is left of the count inside the last
// month, and one to finish (a bad start date skips these); then the result is held.
// s_tready is low from acceptance until the result beat is taken.
// Reset (aresetn low, synchronous) returns the sequencer to idle.
module gregorian_date_add_days_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [13:0] start_year, [17:14] start_month,
                                   // [22:18] start_day, [37:23] days_to_add
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [13:0] result_year, [17:14] result_month,
                                   // [22:18] result_day
    output logic [1:0]  m_tuser    // [0] bad_date, [1] year_overflow
);
    import gdad_pkg::*;

    gdad_cmd_t cmd;
    gdad_sts_t sts;
    logic      in_fire, out_fire;

    logic [YEAR_W-1:0]  res_year;
    logic [MONTH_W-1:0] res_month;
    logic [DAY_W-1:0]   res_day;
    logic               res_bad, res_ovf;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    gdad_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    gdad_dp u_dp (
        .aclk      (aclk),
        .cmd       (cmd),
        .in_year   (s_tdata[13:0]),
        .in_month  (s_tdata[17:14]),
        .in_day    (s_tdata[22:18]),
        .in_count  (s_tdata[37:23]),
        .sts       (sts),
        .res_year  (res_year),
        .res_month (res_month),
        .res_day   (res_day),
        .res_bad   (res_bad),
        .res_ovf   (res_ovf)
    );

    assign m_tdata = {1'b0, res_day, res_month, res_year};
    assign m_tuser = {res_ovf, res_bad};

endmodule
